[design/gdd_pkg.sv]
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the Gregorian date difference unit
// Field widths, controller/datapath command and status structs, and the
// calendar helper functions (month table, leap test on a 400-year residue).
// ----------------------------------------------------------------------------
package gdd_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int DIFF_W = 22;
    // signed running sum, wide enough for the longest year span
    localparam int ACC_W = 24;
    // day-of-year, at most 366 for valid dates and 397 for out-of-range month and day
    localparam int DOY_W = 9;
    // residue of the year modulo the 400-year cycle
    localparam int RES_W = 9;

    localparam logic [YEAR_W-1:0] YEAR_CYCLE = YEAR_W'(400);
    localparam logic [RES_W-1:0] RES_LAST = RES_W'(399);
    localparam logic [RES_W-1:0] RES_CENT1 = RES_W'(100);
    localparam logic [RES_W-1:0] RES_CENT2 = RES_W'(200);
    localparam logic [RES_W-1:0] RES_CENT3 = RES_W'(300);
    localparam logic [ACC_W-1:0] DAYS_COMMON = ACC_W'(365);
    localparam logic [ACC_W-1:0] DAYS_LEAP = ACC_W'(366);
    localparam logic [ACC_W-1:0] DIFF_MAX = ACC_W'(4194303);
    localparam logic [MONTH_W-1:0] MONTH_MARCH = MONTH_W'(3);

    typedef logic [YEAR_W-1:0] year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0] day_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic reduce;
        logic start;
        logic year_step;
        logic finish;
    } gdd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic rem_ge_cycle;
        logic years_equal;
    } gdd_status_t;

    // days in the months before month m, common year; months past twelve count
    // the whole year
    function automatic logic [DOY_W-1:0] days_before(input month_t m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd0, 4'd1: d = DOY_W'(0);
            4'd2: d = DOY_W'(31);
            4'd3: d = DOY_W'(59);
            4'd4: d = DOY_W'(90);
            4'd5: d = DOY_W'(120);
            4'd6: d = DOY_W'(151);
            4'd7: d = DOY_W'(181);
            4'd8: d = DOY_W'(212);
            4'd9: d = DOY_W'(243);
            4'd10: d = DOY_W'(273);
            4'd11: d = DOY_W'(304);
            4'd12: d = DOY_W'(334);
            default: d = DOY_W'(365);
        endcase
        return d;
    endfunction

    // leap year from the year's residue modulo 400; residue zero is a leap year
    function automatic logic is_leap(input logic [RES_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != RES_CENT1) && (r != RES_CENT2)
            && (r != RES_CENT3);
    endfunction

    // day-of-year; February counts when the month is March or later
    function automatic logic [DOY_W-1:0] day_of_year(input month_t m, input day_t d,
                                                     input logic leap);
        return days_before(m) + DOY_W'(d)
            + DOY_W'(leap && (m >= MONTH_MARCH));
    endfunction

endpackage

[design/gdd_in_if.sv]
// ----------------------------------------------------------------------------
// gdd_in_if: input channel of the date difference unit
// Valid/ready channel carrying the two dates of one item.
// ----------------------------------------------------------------------------
interface gdd_in_if;
    logic valid;
    logic ready;
    gdd_pkg::year_t first_year;
    gdd_pkg::month_t first_month;
    gdd_pkg::day_t first_day;
    gdd_pkg::year_t second_year;
    gdd_pkg::month_t second_month;
    gdd_pkg::day_t second_day;

    modport source (
        output valid, first_year, first_month, first_day,
        output second_year, second_month, second_day,
        input ready
    );

    modport sink (
        input valid, first_year, first_month, first_day,
        input second_year, second_month, second_day,
        output ready
    );
endinterface

[design/gdd_out_if.sv]
// ----------------------------------------------------------------------------
// gdd_out_if: result channel of the date difference unit
// Valid/ready channel carrying the day count of one item.
// ----------------------------------------------------------------------------
interface gdd_out_if;
    logic valid;
    logic ready;
    logic [gdd_pkg::DIFF_W-1:0] day_difference;

    modport source (
        output valid, day_difference,
        input ready
    );

    modport sink (
        input valid, day_difference,
        output ready
    );
endinterface

[design/gdd_datapath.sv]
// ----------------------------------------------------------------------------
// gdd_datapath: registers and arithmetic of the date difference unit
// Orders the dates, reduces the earlier year modulo 400, then walks the
// years one per step adding 365 or 366, and clamps the final sum.
// ----------------------------------------------------------------------------
module gdd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gdd_pkg::gdd_cmd_t             cmd,
    output gdd_pkg::gdd_status_t          status,
    input  gdd_pkg::year_t                first_year,
    input  gdd_pkg::month_t               first_month,
    input  gdd_pkg::day_t                 first_day,
    input  gdd_pkg::year_t                second_year,
    input  gdd_pkg::month_t               second_month,
    input  gdd_pkg::day_t                 second_day,
    output logic [gdd_pkg::DIFF_W-1:0]    day_difference
);

    gdd_pkg::year_t cur_reg, cur_next;
    gdd_pkg::year_t rem_reg, rem_next;
    gdd_pkg::month_t m0_reg, m0_next;
    gdd_pkg::day_t d0_reg, d0_next;
    gdd_pkg::year_t y1_reg, y1_next;
    gdd_pkg::month_t m1_reg, m1_next;
    gdd_pkg::day_t d1_reg, d1_next;
    logic signed [gdd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [gdd_pkg::DIFF_W-1:0] diff_reg, diff_next;

    logic later_first;
    logic leap_cur;
    logic [gdd_pkg::RES_W-1:0] res;
    logic [gdd_pkg::ACC_W-1:0] sum;

    // residue is valid once the reduction is done
    assign res = rem_reg[gdd_pkg::RES_W-1:0];
    assign leap_cur = gdd_pkg::is_leap(res);

    // lexicographic order on year, month, day
    assign later_first = {first_year, first_month, first_day}
                       > {second_year, second_month, second_day};

    assign status.rem_ge_cycle = (rem_reg >= gdd_pkg::YEAR_CYCLE);
    assign status.years_equal = (cur_reg == y1_reg);

    // final sum: running total plus day-of-year of the later date
    assign sum = acc_reg + gdd_pkg::ACC_W'(gdd_pkg::day_of_year(m1_reg, d1_reg, leap_cur));

    // next-state logic per command
    always_comb
    begin
        cur_next = cur_reg;
        rem_next = rem_reg;
        m0_next = m0_reg;
        d0_next = d0_reg;
        y1_next = y1_reg;
        m1_next = m1_reg;
        d1_next = d1_reg;
        acc_next = acc_reg;
        diff_next = diff_reg;
        if (cmd.load)
        begin
            if (later_first)
            begin
                cur_next = second_year;
                rem_next = second_year;
                m0_next = second_month;
                d0_next = second_day;
                y1_next = first_year;
                m1_next = first_month;
                d1_next = first_day;
            end
            else
            begin
                cur_next = first_year;
                rem_next = first_year;
                m0_next = first_month;
                d0_next = first_day;
                y1_next = second_year;
                m1_next = second_month;
                d1_next = second_day;
            end
        end
        if (cmd.reduce)
        begin
            rem_next = rem_reg - gdd_pkg::YEAR_CYCLE;
        end
        if (cmd.start)
        begin
            acc_next = gdd_pkg::ACC_W'(0)
                     - gdd_pkg::ACC_W'(gdd_pkg::day_of_year(m0_reg, d0_reg, leap_cur));
        end
        if (cmd.year_step)
        begin
            acc_next = acc_reg + (leap_cur ? gdd_pkg::DAYS_LEAP : gdd_pkg::DAYS_COMMON);
            cur_next = cur_reg + gdd_pkg::YEAR_W'(1);
            rem_next = (res == gdd_pkg::RES_LAST) ? gdd_pkg::YEAR_W'(0)
                                                  : rem_reg + gdd_pkg::YEAR_W'(1);
        end
        if (cmd.finish)
        begin
            // clamp negative spans to zero, saturate large ones
            if (sum[gdd_pkg::ACC_W-1])
            begin
                diff_next = '0;
            end
            else if (sum > gdd_pkg::DIFF_MAX)
            begin
                diff_next = gdd_pkg::DIFF_MAX[gdd_pkg::DIFF_W-1:0];
            end
            else
            begin
                diff_next = sum[gdd_pkg::DIFF_W-1:0];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rem_reg <= rem_next;
        m0_reg <= m0_next;
        d0_reg <= d0_next;
        y1_reg <= y1_next;
        m1_reg <= m1_next;
        d1_reg <= d1_next;
        acc_reg <= acc_next;
        diff_reg <= diff_next;
    end

    assign day_difference = diff_reg;

    // residue stays inside the 400-year cycle while walking years
    a_res_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.year_step |-> (rem_reg < gdd_pkg::YEAR_CYCLE))
        else $error("year residue out of range during year walk");

    // each year step adds a whole common or leap year
    a_year_add: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.year_step |=> ((acc_reg - $past(acc_reg)) == gdd_pkg::DAYS_COMMON
                        || (acc_reg - $past(acc_reg)) == gdd_pkg::DAYS_LEAP))
        else $error("year step added a wrong day count");

endmodule

[design/gdd_controller.sv]
// ----------------------------------------------------------------------------
// gdd_controller: sequencer of the date difference unit
// Steps the datapath through load, year reduction, start, year walk and
// finish, and owns the input ready and output valid.
// ----------------------------------------------------------------------------
module gdd_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  gdd_pkg::gdd_status_t  status,
    output gdd_pkg::gdd_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // sequencing and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (status.rem_ge_cycle)
                begin
                    cmd.reduce = 1'b1;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.years_equal)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                // write the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result appears only out of the finish state
    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside finish");

    // the finish write never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

[design/gregorian_date_difference_unit.sv]
// ----------------------------------------------------------------------------
// gregorian_date_difference_unit: days between two Gregorian dates
// Steps: accept, reduction of the earlier year modulo 400, start, a year walk
//   of one year per cycle, and finish, which waits for a free output register.
// One item at a time; the next is taken once the finish state has passed.
// A result waits in the output register.
// Reset (rst_n, async, low) idles the sequencer and clears the output valid.
// ----------------------------------------------------------------------------
module gregorian_date_difference_unit (
    input  logic       clk,
    input  logic       rst_n,
    gdd_in_if.sink     dates,
    gdd_out_if.source  result
);

    gdd_pkg::gdd_cmd_t cmd;
    gdd_pkg::gdd_status_t status;
    logic in_ready;
    logic out_valid;

    gdd_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dates.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gdd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .first_year     (dates.first_year),
        .first_month    (dates.first_month),
        .first_day      (dates.first_day),
        .second_year    (dates.second_year),
        .second_month   (dates.second_month),
        .second_day     (dates.second_day),
        .day_difference (result.day_difference)
    );

    // handshake outputs
    assign dates.ready = in_ready;
    assign result.valid = out_valid;

endmodule

[test/tb_gregorian_date_difference_unit.sv]
// ----------------------------------------------------------------------------
// tb_gregorian_date_difference_unit: self-checking bench for the date unit
// Drives date pairs over the valid/ready input channel and compares every
// day count on the result channel against an in-bench calendar predictor.
// Directed corner dates come first, then random pairs with idle gaps on both
// sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_gregorian_date_difference_unit;

    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_PAIRS = 80;
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AFTER = 40;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_ERR_LINES = 20;
    localparam int YEAR_TOP = 2**gdd_pkg::YEAR_W - 1;
    localparam longint DAY_COUNT_TOP = 2**gdd_pkg::DIFF_W - 1;
    // sized as if each of about 100 pairs walked every year, plus reduction and
    // idle gaps, taken five times over
    localparam longint CYCLE_LIMIT = 64'd8_300_000;

    // one pending date pair plus the idle cycles the sender waits before it
    typedef struct {
        gdd_pkg::year_t  first_year;
        gdd_pkg::month_t first_month;
        gdd_pkg::day_t   first_day;
        gdd_pkg::year_t  second_year;
        gdd_pkg::month_t second_month;
        gdd_pkg::day_t   second_day;
        int unsigned     idle_before;
    } date_pair_t;

    logic clk = 1'b0;
    logic rst_n;

    gdd_in_if  dates_ch ();
    gdd_out_if result_ch ();

    gregorian_date_difference_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .dates  (dates_ch),
        .result (result_ch)
    );

    date_pair_t                 pending_pairs[$];
    logic [gdd_pkg::DIFF_W-1:0] expected_days[$];

    int err_count = 0;
    int pairs_queued = 0;
    int pairs_sent = 0;
    int days_checked = 0;
    int directed_pairs = 0;
    int long_spans = 0;

    // driver state
    date_pair_t  staged;
    date_pair_t  on_bus;
    bit          have_staged = 1'b0;
    int unsigned wait_left = 0;

    // receiver state
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          rgap_left = 0;
    int          taken = 0;

    // clock
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------
    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // leap years among 1..y
    function automatic longint leaps_through(input longint y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic int month_length(input int m, input bit leap);
        case (m)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // day of year; months past twelve count the whole table, month zero none
    function automatic longint ordinal_day(input longint y, input longint m,
                                           input longint d);
        longint total;
        longint prior_months;
        total = d;
        prior_months = (m > 12) ? 12 : ((m > 0) ? m - 1 : 0);
        for (int k = 1; k <= prior_months; k++)
            total += month_length(k, leap_year(y));
        return total;
    endfunction

    function automatic logic [gdd_pkg::DIFF_W-1:0] predict_day_difference(
        input date_pair_t p);
        longint ya, ma, da, yb, mb, db, t, span;
        ya = p.first_year;
        ma = p.first_month;
        da = p.first_day;
        yb = p.second_year;
        mb = p.second_month;
        db = p.second_day;
        // earlier date first
        if ((ya > yb) || (ya == yb && ma > mb) || (ya == yb && ma == mb && da > db))
        begin
            t = ya; ya = yb; yb = t;
            t = ma; ma = mb; mb = t;
            t = da; da = db; db = t;
        end
        if (ya == yb)
        begin
            span = ordinal_day(yb, mb, db) - ordinal_day(ya, ma, da);
        end
        else
        begin
            span = (leap_year(ya) ? 366 : 365) - ordinal_day(ya, ma, da)
                 + ordinal_day(yb, mb, db)
                 + 365 * (yb - 1 - ya) + leaps_through(yb - 1) - leaps_through(ya);
        end
        // unchecked dates can go negative; huge spans saturate
        if (span < 0)
            span = 0;
        if (span > DAY_COUNT_TOP)
            span = DAY_COUNT_TOP;
        return span[gdd_pkg::DIFF_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 48);
    endfunction

    function automatic int pick_month();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 12);
        else
            return $urandom_range(0, 15);
    endfunction

    function automatic int pick_day(input int y, input int m);
        if ($urandom_range(0, 99) < 85 && m >= 1 && m <= 12)
            return $urandom_range(1, month_length(m, leap_year(y)));
        else
            return $urandom_range(0, 31);
    endfunction

    task automatic queue_pair(input int y0, input int m0, input int d0,
                              input int y1, input int m1, input int d1,
                              input int unsigned idle);
        date_pair_t p;
        p.first_year = gdd_pkg::year_t'(y0);
        p.first_month = gdd_pkg::month_t'(m0);
        p.first_day = gdd_pkg::day_t'(d0);
        p.second_year = gdd_pkg::year_t'(y1);
        p.second_month = gdd_pkg::month_t'(m1);
        p.second_day = gdd_pkg::day_t'(d1);
        p.idle_before = idle;
        pending_pairs.push_back(p);
        pairs_queued++;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > 1000)
            long_spans++;
    endtask

    task automatic flag_error(input string msg);
        if (err_count < MAX_ERR_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // input driver: records each transfer, then stages the next pair
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_dates
        bit bus_free;
        if (!rst_n)
        begin
            dates_ch.valid <= 1'b0;
        end
        else
        begin
            if (dates_ch.valid && dates_ch.ready)
            begin
                expected_days.push_back(predict_day_difference(on_bus));
                pairs_sent++;
            end
            bus_free = !dates_ch.valid || dates_ch.ready;
            if (bus_free)
            begin
                if (!have_staged && pending_pairs.size() > 0)
                begin
                    staged = pending_pairs.pop_front();
                    have_staged = 1'b1;
                    wait_left = staged.idle_before;
                end
                if (have_staged && wait_left == 0)
                begin
                    dates_ch.valid <= 1'b1;
                    dates_ch.first_year <= staged.first_year;
                    dates_ch.first_month <= staged.first_month;
                    dates_ch.first_day <= staged.first_day;
                    dates_ch.second_year <= staged.second_year;
                    dates_ch.second_month <= staged.second_month;
                    dates_ch.second_day <= staged.second_day;
                    on_bus = staged;
                    have_staged = 1'b0;
                end
                else
                begin
                    dates_ch.valid <= 1'b0;
                    if (have_staged)
                        wait_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result ready: random gaps, one long hold-off to back up the input
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_ready
        bit xfer;
        bit quiet;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            xfer = result_ch.valid && result_ch.ready;
            if (xfer)
                taken++;
            quiet = ((taken / 16) % 3) == 1;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!hold_done && taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (rgap_left > 0)
            begin
                rgap_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!quiet && (xfer || $urandom_range(0, 31) == 0))
                    rgap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result transfer against the oldest expected day count
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_days
        logic [gdd_pkg::DIFF_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_days.size() == 0)
            begin
                flag_error($sformatf("unexpected day count %0d",
                                     result_ch.day_difference));
            end
            else
            begin
                want = expected_days.pop_front();
                if (result_ch.day_difference !== want)
                    flag_error($sformatf("day_difference %0d, expected %0d (result %0d)",
                                         result_ch.day_difference, want, days_checked));
            end
            days_checked++;
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        longint cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycles, expected_days.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int i;
        int y0, m0, d0, y1, m1, d1, delta, t;
        bit quiet;
        int unsigned idle;

        rst_n = 1'b0;
        dates_ch.valid = 1'b0;
        dates_ch.first_year = '0;
        dates_ch.first_month = '0;
        dates_ch.first_day = '0;
        dates_ch.second_year = '0;
        dates_ch.second_month = '0;
        dates_ch.second_day = '0;
        result_ch.ready = 1'b0;

        // directed corners
        queue_pair(2024, 2, 29, 2024, 2, 29, 0);        // same date
        queue_pair(1, 1, 1, 9999, 12, 31, 0);           // full nominal range
        queue_pair(9999, 12, 31, 1, 1, 1, 2);           // same, later date first
        queue_pair(0, 1, 1, 1, 1, 1, 0);                // year zero is leap
        queue_pair(YEAR_TOP, 15, 31, 0, 0, 0, 0);       // saturates
        queue_pair(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31, 1);
        queue_pair(2023, 12, 31, 2023, 13, 0, 0);       // month past twelve, zero span
        queue_pair(2000, 0, 5, 2000, 1, 5, 0);          // month zero
        queue_pair(1999, 3, 0, 1999, 2, 28, 0);         // day zero
        queue_pair(2001, 2, 31, 2001, 3, 1, 3);         // day past month end
        queue_pair(2000, 2, 28, 2000, 3, 1, 0);         // leap by 400
        queue_pair(1900, 2, 28, 1900, 3, 1, 0);         // century, not leap
        queue_pair(2004, 2, 28, 2004, 3, 1, 0);
        queue_pair(2100, 3, 1, 2100, 2, 28, 0);
        queue_pair(1999, 12, 31, 2000, 1, 1, 0);        // across one boundary
        queue_pair(2020, 5, 20, 2020, 5, 10, 0);        // day order only
        queue_pair(1998, 15, 31, 2003, 14, 0, 5);       // months past twelve
        queue_pair(1600, 1, 1, 2000, 1, 1, 0);          // one 400-year cycle
        queue_pair(400, 12, 31, 401, 1, 1, 0);
        queue_pair(9999, 12, 31, 10000, 1, 1, 0);
        directed_pairs = pairs_queued;

        // random pairs: mostly short spans, a few huge ones
        for (i = 0; i < RANDOM_PAIRS; i++)
        begin
            quiet = ((i / 12) % 3) == 1;
            t = $urandom_range(0, 99);
            y0 = $urandom_range(0, YEAR_TOP);
            if (t < 6)
            begin
                y1 = $urandom_range(0, YEAR_TOP);
            end
            else if (t < 20)
            begin
                y1 = y0;
            end
            else
            begin
                delta = $urandom_range(1, 40);
                y1 = (y0 + delta > YEAR_TOP) ? y0 - delta : y0 + delta;
            end
            if ($urandom_range(0, 1))
            begin
                t = y0; y0 = y1; y1 = t;
            end
            m0 = pick_month();
            d0 = pick_day(y0, m0);
            m1 = pick_month();
            d1 = pick_day(y1, m1);
            idle = quiet ? 0 : pick_gap();
            queue_pair(y0, m0, d0, y1, m1, d1, idle);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every pair sent and every day count seen
        while (pairs_sent < pairs_queued || expected_days.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d day counts from %0d date pairs: %0d directed, %0d random,",
                 days_checked, pairs_sent, directed_pairs, pairs_sent - directed_pairs);
        $display("  %0d spans over a thousand years, one %0d-cycle output hold-off.",
                 long_spans, HOLD_CYCLES);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
design/gdd_pkg.sv
design/gdd_in_if.sv
design/gdd_out_if.sv
design/gdd_datapath.sv
design/gdd_controller.sv
design/gregorian_date_difference_unit.sv
test/tb_gregorian_date_difference_unit.sv
